FILE: sv/tile_flood_fill_editor_assert.svh
// Assertion macros for the tile flood fill editor
`ifndef TILE_FLOOD_FILL_EDITOR_ASSERT_SVH
`define TILE_FLOOD_FILL_EDITOR_ASSERT_SVH
// implication checked on every clock, skipped during reset
`define TFF_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define TFF_ASSERT_NXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

FILE: sv/tffe_pkg.sv
// Package for the tile flood fill editor: sizes, command codes, states, structs
package tffe_pkg;
	localparam int TileSize = 16;
	localparam int Tiles = 16;
	localparam int CoordW = $clog2(TileSize);
	localparam int PixW = 2 * CoordW;
	localparam int PixCnt = TileSize * TileSize;
	localparam int TileW = $clog2(Tiles);
	localparam int AddrW = TileW + PixW;
	localparam int SpW = PixW + 1;

	typedef enum logic [2:0] {
		CMD_PLOT = 3'd0,
		CMD_ERASE = 3'd1,
		CMD_FLOOD = 3'd2,
		CMD_FILL = 3'd3,
		CMD_READ = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_WAIT,
		ST_DECIDE,
		ST_CLEAR,
		ST_SEED,
		ST_FILL,
		ST_POP,
		ST_POPWAIT,
		ST_CHECK,
		ST_NBR_RD,
		ST_NBR,
		ST_FINAL_RD,
		ST_FINAL_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_RD_SEED,
		OP_WR_SEED,
		OP_INIT_STEP,
		OP_CLR_STEP,
		OP_FILL_STEP,
		OP_PUSH_SEED,
		OP_POP,
		OP_RD_TOP,
		OP_PAINT,
		OP_NBR_STEP,
		OP_RD_FINAL,
		OP_SHOW
	} op_t;

	typedef struct packed {
		op_t op;
	} ctl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic differs;
		logic target_eq_paint;
		logic cnt_last;
		logic sp_zero;
		logic pix_eq_target;
		logic dir_last;
		logic init_last;
		logic out_valid;
	} sts_t;
endpackage

FILE: sv/tile_flood_fill_editor.sv
// Top level of the tile flood fill editor
// channel | handshake      | payload
// in      | valid/stall    | command col row color
// out     | out_valid/stall| pixel_value region_changed
// cfg     | valid/ready    | tile_select
// Plot, erase, read, unused codes, flood no-op: read the seed pixel, write it for plot or erase, show the result.
// Fill tile: writes every pixel of the selected tile, one tile memory write per cycle.
// Flood fill: clear the visited bits and push the seed, then pop entries, paint each popped
// pixel that matches the target color and check its four neighbors, pushing unvisited ones.
// Reset: all 4096 tile memory entries are cleared, in_stall high meanwhile.
// One item at a time; a stalled result holds the next item at its result.
module tile_flood_fill_editor import tffe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] command,
	input logic [3:0] col,
	input logic [3:0] row,
	input logic [2:0] color,
	output logic out_valid,
	input logic out_stall,
	output logic [3:0] pixel_value,
	output logic region_changed,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [3:0] cfg_data
);
	`include "tile_flood_fill_editor_assert.svh"
	logic [TileW-1:0] tile_select_q;
	ctl_t ctl;
	sts_t sts;
	logic busy, in_fire;

	assign cfg_ready = 1'b1;
	assign in_stall = busy;
	assign in_fire = in_valid && !busy;
	assign out_valid = sts.out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tile_select_q <= '0;
		else if (cfg_valid && cfg_ready)
			tile_select_q <= cfg_data[TileW-1:0];
	end

	tffe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .sts(sts), .ctl(ctl), .busy(busy)
	);

	tffe_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .tile_sel(tile_select_q), .command(command),
		.col(col), .row(row), .color(color), .ctl(ctl),
		.out_take(sts.out_valid && !out_stall), .sts(sts),
		.pixel_value(pixel_value), .region_changed(region_changed)
	);

	`TFF_ASSERT_IMP(a_no_accept_busy, busy, !in_fire)
	`TFF_ASSERT_NXT(a_busy_after_accept, in_fire, busy)
endmodule

FILE: sv/tffe_datapath.sv
// Datapath: tile memory, visited bits, coordinate stack and result register
module tffe_datapath import tffe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [TileW-1:0] tile_sel,
	input logic [2:0] command,
	input logic [CoordW-1:0] col,
	input logic [CoordW-1:0] row,
	input logic [2:0] color,
	input ctl_t ctl,
	input logic out_take,
	output sts_t sts,
	output logic [3:0] pixel_value,
	output logic region_changed
);
	logic [3:0] mem [0:Tiles*PixCnt-1];
	logic [PixW-1:0] stk [0:PixCnt-1];
	logic vis_mem [0:PixCnt-1];
	logic vis_rd_q;
	logic [3:0] rd_q;
	logic [AddrW-1:0] rd_addr, wr_addr;
	logic [AddrW-1:0] init_q;
	logic [3:0] wr_data;
	logic wr_en;
	logic [2:0] cmd_q;
	logic [PixW-1:0] pix_q, cur_q, cnt_q, top_q, nidx;
	logic [3:0] paint_q, target_q;
	logic [TileW-1:0] tile_q;
	logic [SpW-1:0] sp_q;
	logic changed_q, out_valid_q;
	logic [1:0] dir_q;
	logic [CoordW-1:0] cx, cy;
	logic nok, push_en;
	logic [PixW-1:0] push_idx;

	assign cx = cur_q[CoordW-1:0];
	assign cy = cur_q[PixW-1:CoordW];

	always_comb begin
		nok = 1'b0;
		nidx = cur_q;
		case (dir_q)
			2'd0: begin
				nok = cx != '0;
				nidx = cur_q - PixW'(1);
			end
			2'd1: begin
				nok = cy != '0;
				nidx = cur_q - PixW'(TileSize);
			end
			2'd2: begin
				nok = cx != CoordW'(TileSize - 1);
				nidx = cur_q + PixW'(1);
			end
			default: begin
				nok = cy != CoordW'(TileSize - 1);
				nidx = cur_q + PixW'(TileSize);
			end
		endcase
	end

	always_comb begin
		rd_addr = {tile_q, pix_q};
		wr_addr = {tile_q, pix_q};
		wr_data = paint_q;
		wr_en = 1'b0;
		push_en = 1'b0;
		push_idx = pix_q;
		case (ctl.op)
			OP_INIT_STEP: begin
				wr_en = 1'b1;
				wr_addr = init_q;
				wr_data = 4'd0;
			end
			OP_WR_SEED: begin
				wr_en = (cmd_q == CMD_PLOT) || (cmd_q == CMD_ERASE);
				wr_data = (cmd_q == CMD_ERASE) ? 4'd0 : paint_q;
			end
			OP_FILL_STEP: begin
				wr_en = 1'b1;
				rd_addr = {tile_q, cnt_q};
				wr_addr = {tile_q, cnt_q};
			end
			OP_PUSH_SEED: push_en = 1'b1;
			OP_RD_TOP: rd_addr = {tile_q, top_q};
			OP_PAINT: begin
				wr_en = rd_q == target_q;
				wr_addr = {tile_q, cur_q};
			end
			OP_NBR_STEP: begin
				push_en = nok && !vis_rd_q;
				push_idx = nidx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
		if (push_en)
			stk[sp_q[PixW-1:0]] <= push_idx;
		top_q <= stk[sp_q[PixW-1:0] - PixW'(1)];
		if (ctl.op == OP_CLR_STEP)
			vis_mem[cnt_q] <= 1'b0;
		else if (push_en)
			vis_mem[push_idx] <= 1'b1;
		vis_rd_q <= vis_mem[nidx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			sp_q <= '0;
			out_valid_q <= 1'b0;
			changed_q <= 1'b0;
			cnt_q <= '0;
			dir_q <= '0;
		end else begin
			if (out_take)
				out_valid_q <= 1'b0;
			if (push_en)
				sp_q <= sp_q + SpW'(1);
			case (ctl.op)
				OP_INIT_STEP: init_q <= init_q + AddrW'(1);
				OP_LATCH: begin
					changed_q <= 1'b0;
					cnt_q <= '0;
				end
				OP_CLR_STEP: begin
					cnt_q <= cnt_q + PixW'(1);
					sp_q <= '0;
					changed_q <= 1'b1;
				end
				OP_WR_SEED: changed_q <= sts.differs &&
					((cmd_q == CMD_PLOT) || (cmd_q == CMD_ERASE));
				OP_FILL_STEP: begin
					cnt_q <= cnt_q + PixW'(1);
					if (cnt_q != '0 && rd_q != paint_q)
						changed_q <= 1'b1;
				end
				OP_POP: sp_q <= sp_q - SpW'(1);
				OP_PAINT: dir_q <= '0;
				OP_NBR_STEP: dir_q <= dir_q + 2'd1;
				// last pixel of a tile fill is compared here
				OP_RD_FINAL: if (cmd_q == CMD_FILL && rd_q != paint_q)
					changed_q <= 1'b1;
				OP_SHOW: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LATCH: begin
				cmd_q <= command;
				pix_q <= {row, col};
				paint_q <= {1'b1, color};
				tile_q <= tile_sel;
			end
			OP_WR_SEED: target_q <= rd_q;
			OP_RD_TOP: cur_q <= top_q;
			OP_SHOW: begin
				pixel_value <= rd_q;
				region_changed <= changed_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.cmd = cmd_q;
		sts.differs = (cmd_q == CMD_ERASE) ? (rd_q != 4'd0) : (rd_q != paint_q);
		sts.target_eq_paint = rd_q == paint_q;
		sts.cnt_last = cnt_q == PixW'(PixCnt - 1);
		sts.sp_zero = sp_q == '0;
		sts.pix_eq_target = rd_q == target_q;
		sts.dir_last = dir_q == 2'd3;
		sts.init_last = init_q == '1;
		sts.out_valid = out_valid_q;
	end
endmodule

FILE: sv/tffe_ctrl.sv
// Controller state machine sequencing every command
module tffe_ctrl import tffe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input sts_t sts,
	output ctl_t ctl,
	output logic busy
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (sts.init_last) state_d = ST_IDLE;
			ST_IDLE: if (in_fire) state_d = ST_RD;
			ST_RD: state_d = ST_WAIT;
			ST_WAIT: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (sts.cmd == CMD_FLOOD)
					state_d = sts.target_eq_paint ? ST_FINAL_RD : ST_CLEAR;
				else if (sts.cmd == CMD_FILL)
					state_d = ST_FILL;
				else
					state_d = ST_FINAL_RD;
			end
			ST_CLEAR: if (sts.cnt_last) state_d = ST_SEED;
			ST_SEED: state_d = ST_POP;
			ST_FILL: if (sts.cnt_last) state_d = ST_FINAL_RD;
			ST_POP: state_d = sts.sp_zero ? ST_FINAL_RD : ST_POPWAIT;
			ST_POPWAIT: state_d = ST_CHECK;
			ST_CHECK: state_d = sts.pix_eq_target ? ST_NBR_RD : ST_POP;
			ST_NBR_RD: state_d = ST_NBR;
			ST_NBR: state_d = sts.dir_last ? ST_POP : ST_NBR_RD;
			ST_FINAL_RD: state_d = ST_FINAL_WAIT;
			ST_FINAL_WAIT: state_d = ST_OUT;
			ST_OUT: if (!sts.out_valid) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.op = OP_NONE;
		busy = state_q != ST_IDLE;
		case (state_q)
			ST_INIT: ctl.op = OP_INIT_STEP;
			ST_IDLE: if (in_fire) ctl.op = OP_LATCH;
			ST_RD: ctl.op = OP_RD_SEED;
			ST_WAIT: ctl.op = OP_NONE;
			ST_DECIDE: ctl.op = OP_WR_SEED;
			ST_CLEAR: ctl.op = OP_CLR_STEP;
			ST_SEED: ctl.op = OP_PUSH_SEED;
			ST_FILL: ctl.op = OP_FILL_STEP;
			ST_POP: ctl.op = sts.sp_zero ? OP_NONE : OP_POP;
			ST_POPWAIT: ctl.op = OP_RD_TOP;
			ST_CHECK: ctl.op = OP_PAINT;
			ST_NBR_RD: ctl.op = OP_NONE;
			ST_NBR: ctl.op = OP_NBR_STEP;
			ST_FINAL_RD: ctl.op = OP_RD_FINAL;
			ST_FINAL_WAIT: ctl.op = OP_NONE;
			ST_OUT: ctl.op = sts.out_valid ? OP_NONE : OP_SHOW;
			default: ctl.op = OP_NONE;
		endcase
	end
endmodule
